/* hw/rtl/binary_to_decimal_ascii_top_assert.svh */
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define B2DA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define B2DA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/b2da_pkg.sv */
package b2da_pkg;

  localparam int NUMBER_BITS = 32;
  localparam int IN_W        = 32;
  localparam int CHAR_W      = 6;
  localparam int DIGIT_W     = 4;
  localparam int DIGITS      = (NUMBER_BITS * 30103 + 99999) / 100000;
  localparam int BCD_W       = DIGITS * DIGIT_W;
  localparam int POS_W       = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int STEPS       = 4;
  localparam int STAGES      = (NUMBER_BITS + STEPS - 1) / STEPS;
  localparam int PAD_W       = STAGES * STEPS;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
  localparam logic [DIGIT_W-1:0] ADD_LIMIT  = DIGIT_W'(5);
  localparam logic [DIGIT_W-1:0] ADD_FIX    = DIGIT_W'(3);

  typedef logic [DIGITS-1:0][DIGIT_W-1:0] bcd_t;

  // a group of double dabble steps, one input bit each, msb first
  function automatic logic [BCD_W-1:0] dabble_group(input logic [BCD_W-1:0] bcd,
                                                    input logic [STEPS-1:0] bits);
    logic [BCD_W-1:0] acc;
    acc = bcd;
    for (int s = STEPS - 1; s >= 0; s--) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (acc[d*DIGIT_W +: DIGIT_W] >= ADD_LIMIT) begin
          acc[d*DIGIT_W +: DIGIT_W] = acc[d*DIGIT_W +: DIGIT_W] + ADD_FIX;
        end
      end
      acc = {acc[BCD_W-2:0], bits[s]};
    end
    return acc;
  endfunction

endpackage

/* hw/rtl/b2da_dabble.sv */
module b2da_dabble (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [b2da_pkg::IN_W-1:0]     number_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [b2da_pkg::BCD_W-1:0]    bcd_o
);

  localparam int STAGES = b2da_pkg::STAGES;
  localparam int PAD_W  = b2da_pkg::PAD_W;
  localparam int BCD_W  = b2da_pkg::BCD_W;
  localparam int STEPS  = b2da_pkg::STEPS;

  logic [STAGES-1:0] vld_q;
  logic [BCD_W-1:0]  bcd_q [STAGES];
  logic [PAD_W-1:0]  num_q [STAGES];
  logic [STAGES:0]   rdy;
  logic [STAGES-1:0] vld_in;
  logic [BCD_W-1:0]  bcd_in [STAGES];
  logic [PAD_W-1:0]  num_in [STAGES];

  always_comb begin
    rdy[STAGES] = !stall_i;
    for (int k = STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_in[0] = valid_i;
    bcd_in[0] = '0;
    num_in[0] = PAD_W'(number_i[b2da_pkg::NUMBER_BITS-1:0]);
    for (int k = 1; k < STAGES; k++) begin
      vld_in[k] = vld_q[k-1];
      bcd_in[k] = bcd_q[k-1];
      num_in[k] = num_q[k-1];
    end
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && vld_in[k]) begin
        bcd_q[k] <= b2da_pkg::dabble_group(bcd_in[k], num_in[k][PAD_W-1 -: STEPS]);
        num_q[k] <= num_in[k] << STEPS;
      end
    end
  end

  assign stall_o = !rdy[0];
  assign valid_o = vld_q[STAGES-1];
  assign bcd_o   = bcd_q[STAGES-1];

endmodule

/* hw/rtl/b2da_serial.sv */
`include "binary_to_decimal_ascii_top_assert.svh"

module b2da_serial (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [b2da_pkg::BCD_W-1:0]    bcd_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [b2da_pkg::CHAR_W-1:0]   digit_char_o,
  output logic                          last_digit_o
);

  localparam int POS_W  = b2da_pkg::POS_W;
  localparam int DIGITS = b2da_pkg::DIGITS;

  b2da_pkg::bcd_t            bcd_q;
  b2da_pkg::bcd_t            bcd_in;
  logic [POS_W-1:0]          pos_q;
  logic [POS_W-1:0]          lead;
  logic                      busy_q;
  logic                      out_vld_q;
  logic [b2da_pkg::CHAR_W-1:0] char_q;
  logic                      last_q;
  logic                      out_free;
  logic                      emit;
  logic                      finish;
  logic                      take;

  assign bcd_in   = bcd_i;
  assign out_free = !out_vld_q || !stall_i;
  assign emit     = busy_q && out_free;
  assign finish   = emit && (pos_q == '0);
  assign take     = valid_i && (!busy_q || finish);
  assign stall_o  = busy_q && !finish;

  // position of the leading nonzero digit, zero for a zero value
  always_comb begin
    lead = '0;
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd_in[d] != '0) begin
        lead = POS_W'(d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (take) begin
        busy_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (!stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      bcd_q <= bcd_in;
      pos_q <= lead;
    end else if (emit) begin
      pos_q <= pos_q - POS_W'(1);
    end
    if (emit) begin
      char_q <= b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(bcd_q[pos_q]);
      last_q <= (pos_q == '0);
    end
  end

  assign valid_o      = out_vld_q;
  assign digit_char_o = char_q;
  assign last_digit_o = last_q;

  `B2DA_ASSERT_NEXT(a_done_clears_busy, finish && !valid_i, !busy_q, "busy after last digit")
  `B2DA_ASSERT_NEXT(a_pos_holds, busy_q && !out_free, busy_q && $stable(pos_q), "digit lost on stall")
  `B2DA_ASSERT_NOW(a_char_range, out_vld_q, (char_q >= 6'd48) && (char_q <= 6'd57), "bad char")

endmodule

/* hw/rtl/binary_to_decimal_ascii_top.sv */
// Converts an unsigned binary number to decimal ASCII digits, most significant
// first, without leading zeros; zero gives a single '0', and the final
// character of each number carries last_digit_o. A number passes through an
// eight-stage double dabble pipeline (four bit steps per stage), then a
// serializer sends one character per cycle from its output register unless
// out_stall_i holds it. A number has 1 to 10 digits, and the serializer takes
// the next one in the same cycle that it emits the last digit of the current.
module binary_to_decimal_ascii_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [b2da_pkg::IN_W-1:0]   number_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [b2da_pkg::CHAR_W-1:0] digit_char_o,
  output logic                        last_digit_o
);

  logic                        bcd_vld;
  logic                        bcd_stall;
  logic [b2da_pkg::BCD_W-1:0]  bcd;

  b2da_dabble u_dabble (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .stall_o  (in_stall_o),
    .number_i (number_i),
    .valid_o  (bcd_vld),
    .stall_i  (bcd_stall),
    .bcd_o    (bcd)
  );

  b2da_serial u_serial (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (bcd_vld),
    .stall_o      (bcd_stall),
    .bcd_i        (bcd),
    .valid_o      (out_valid_o),
    .stall_i      (out_stall_i),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o)
  );

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int DIRECTED_MAX  = 25;
  localparam int RANDOM_ITEMS  = 130;
  localparam int MAX_DIGITS    = 10;
  localparam int LONG_HOLD     = 400;
  localparam int HOLD_AT_CHARS = 50;
  localparam int TAIL_CYCLES   = 40;

  typedef struct packed {
    logic [b2da_pkg::CHAR_W-1:0] code;
    logic                        last;
  } decimal_char_t;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic [b2da_pkg::IN_W-1:0]   number_i    = '0;
  logic                        out_stall_i = 1'b0;
  logic                        in_stall_o;
  logic                        out_valid_o;
  logic [b2da_pkg::CHAR_W-1:0] digit_char_o;
  logic                        last_digit_o;

  logic [b2da_pkg::IN_W-1:0] pending_numbers[$];
  decimal_char_t             expected_chars[$];
  int                        mismatch_count = 0;
  int                        chars_checked  = 0;

  logic                      send_valid;
  logic [b2da_pkg::IN_W-1:0] send_number;
  int                        burst_left;
  int                        gap_left;

  logic          next_stall;
  int            stall_left;
  int            hold_left;
  bit            hold_done;
  decimal_char_t want;

  binary_to_decimal_ascii_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .number_i    (number_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .digit_char_o(digit_char_o),
    .last_digit_o(last_digit_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // decimal digits of the masked number, most significant first
  task automatic queue_decimal_chars(input logic [b2da_pkg::IN_W-1:0] number);
    longint unsigned value;
    logic [b2da_pkg::DIGIT_W-1:0] digits[MAX_DIGITS];
    int count;
    decimal_char_t ch;
    value = longint'(number) & ((64'd1 << b2da_pkg::NUMBER_BITS) - 64'd1);
    count = 0;
    do begin
      digits[count] = b2da_pkg::DIGIT_W'(value % 10);
      value = value / 10;
      count++;
    end while (value != 0 && count < MAX_DIGITS);
    for (int k = count - 1; k >= 0; k--) begin
      ch.code = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(digits[k]);
      ch.last = (k == 0);
      expected_chars.push_back(ch);
    end
  endtask

  function automatic logic [b2da_pkg::IN_W-1:0] random_with_digits(input int ndigits);
    longint unsigned lo;
    longint unsigned hi;
    lo = 1;
    for (int k = 1; k < ndigits; k++) lo = lo * 10;
    hi = lo * 10 - 1;
    if (ndigits == 1) lo = 0;
    if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
    return b2da_pkg::IN_W'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
  endfunction

  // sender: bursts of transactions separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      number_i   <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      send_valid  = in_valid_i;
      send_number = number_i;
      if (in_valid_i && !in_stall_o) begin
        queue_decimal_chars(number_i);
        send_valid = 1'b0;
      end
      if (!send_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_numbers.size() > 0) begin
          send_valid  = 1'b1;
          send_number = pending_numbers.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_valid_i <= send_valid;
      number_i   <= send_number;
    end
  end

  // receiver: checks characters and stalls on its own pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected character %0d last %0b",
                                    digit_char_o, last_digit_o));
        end else begin
          want = expected_chars.pop_front();
          if (digit_char_o !== want.code) begin
            report_mismatch($sformatf("digit_char got %0d want %0d",
                                      digit_char_o, want.code));
          end
          if (last_digit_o !== want.last) begin
            report_mismatch($sformatf("last_digit got %0b want %0b (char %0d)",
                                      last_digit_o, want.last, want.code));
          end
        end
        chars_checked++;
      end
      next_stall = out_stall_i;
      if (!hold_done && chars_checked >= HOLD_AT_CHARS) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_stall = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        next_stall = 1'b0;
        stall_left = $urandom_range(10, 40);
      end else begin
        next_stall = 1'($urandom_range(0, 1));
        stall_left = $urandom_range(0, 6);
      end
      out_stall_i <= next_stall;
    end
  end

  initial begin
    logic [b2da_pkg::IN_W-1:0] directed[$];
    directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd12345,
                 32'd99999, 32'd100000, 32'd999999999, 32'd1000000000,
                 32'd4294967295, 32'd4294967294, 32'd2147483648,
                 32'h5555_5555, 32'hAAAA_AAAA, 32'd4000000000, 32'd1000000001,
                 32'd7, 32'd0};
    for (int k = 0; k < directed.size() && k < DIRECTED_MAX; k++) begin
      pending_numbers.push_back(directed[k]);
    end
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        pending_numbers.push_back($urandom);
      end else begin
        pending_numbers.push_back(random_with_digits($urandom_range(1, MAX_DIGITS)));
      end
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_numbers.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_chars.size() > 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("binary_to_decimal_ascii_top test passed");
    end else begin
      $display("binary_to_decimal_ascii_top test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("binary_to_decimal_ascii_top test failed");
    $finish;
  end

endmodule

/* binary_to_decimal_ascii_top.f */
+incdir+hw/rtl
hw/rtl/b2da_pkg.sv
hw/rtl/b2da_dabble.sv
hw/rtl/b2da_serial.sv
hw/rtl/binary_to_decimal_ascii_top.sv
test/testbench.sv
